// File: hw/rtl/sspg_pkg.sv
// Package for the stepper step pulse generator.
// Holds field widths, register map, reset values and shared structs.
// No dependencies.
`default_nettype none

package sspg_pkg;

  localparam int unsigned PERIOD_WIDTH_DEF     = 16;
  localparam int unsigned STEP_COUNT_WIDTH_DEF = 32;

  localparam int unsigned VEL_W    = 16;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned NUM_W    = 22;
  localparam int unsigned APP_W    = 16;
  localparam int unsigned ANG_W    = 23;
  localparam int unsigned PER_OUT_W  = 16;
  localparam int unsigned STEP_OUT_W = 32;
  localparam int unsigned OUT_FIELDS_W = 3 + PER_OUT_W + STEP_OUT_W + ANG_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [1:0] REG_STOP_THRESHOLD   = 2'd0;
  localparam logic [1:0] REG_PERIOD_NUMERATOR = 2'd1;
  localparam logic [1:0] REG_ANGLE_PER_PULSE  = 2'd2;

  localparam logic REQ_COMMAND = 1'b0;
  localparam logic REQ_TICK    = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(100);
  localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(3790600);
  localparam logic [APP_W-1:0] APP_RESET = APP_W'(379);

  localparam int PI_URAD     = 3141593;
  localparam int TWO_PI_URAD = 6283185;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic pulse;
    logic dir;
  } trk_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/stepper_step_pulse_generator.sv
// Top level of the stepper step pulse generator for one motor channel.
// Uses sspg_pkg, sspg_div and sspg_track.
// A tick transaction passes through S_FIN into the output register. A velocity
// command passes through S_DIV, waiting for the bit-serial period divider,
// which retires one quotient bit per clock. One transaction is processed at a
// time; the next is accepted while the previous result waits in the output
// register. Configuration registers sit at byte addresses 0, 4 and 8.
`default_nettype none

module stepper_step_pulse_generator import sspg_pkg::*; #(
  parameter int unsigned PERIOD_WIDTH     = PERIOD_WIDTH_DEF,
  parameter int unsigned STEP_COUNT_WIDTH = STEP_COUNT_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [VEL_W-1:0]      in_tdata,   // [15:0] velocity
  input  wire logic                  in_tuser,   // [0] req_type
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] step_pulse, [1] direction, [2] running, [18:3] period,
  // [50:19] step_count, [73:51] angle, [79:74] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  localparam int unsigned CMP_W = (PERIOD_WIDTH > NUM_W) ? PERIOD_WIDTH : NUM_W;
  localparam logic [PERIOD_WIDTH-1:0] PMAX = {PERIOD_WIDTH{1'b1}};

  state_t state_r, state_nxt;

  logic [THR_W-1:0] thr_r;
  logic [NUM_W-1:0] num_r;
  logic [APP_W-1:0] app_r;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  logic [PERIOD_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [PERIOD_WIDTH-1:0] period_r, period_nxt, period_sat;
  logic                    en_r, en_nxt;
  logic                    dir_r, dir_nxt;
  logic                    pulse_r, pulse_nxt;
  logic                    stop_r, neg_r, zero_r;
  logic                    stop_nxt, neg_nxt, zero_nxt;

  logic                    in_acc;
  logic                    vel_neg;
  logic [MAG_W-1:0]        vel_mag;
  logic                    div_start;
  div_stat_t               div_stat;
  logic [NUM_W-1:0]        quotient;
  trk_ctl_t                trk_ctl;
  logic [STEP_COUNT_WIDTH-1:0] step_count;
  logic signed [ANG_W-1:0]     angle;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_load;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      num_r <= NUM_RESET;
      app_r <= APP_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_STOP_THRESHOLD:   thr_r <= cfg_pwdata[THR_W-1:0];
        REG_PERIOD_NUMERATOR: num_r <= cfg_pwdata[NUM_W-1:0];
        REG_ANGLE_PER_PULSE:  app_r <= cfg_pwdata[APP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STOP_THRESHOLD:   cfg_prdata = CFG_DATA_W'(thr_r);
      REG_PERIOD_NUMERATOR: cfg_prdata = CFG_DATA_W'(num_r);
      REG_ANGLE_PER_PULSE:  cfg_prdata = CFG_DATA_W'(app_r);
      default:              cfg_prdata = '0;
    endcase
  end

  // Input decode.
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign vel_neg   = in_tdata[VEL_W-1];
  assign vel_mag   = vel_neg ? MAG_W'(-in_tdata) : MAG_W'(in_tdata);
  assign div_start = in_acc & (in_tuser == REQ_COMMAND);

  sspg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (vel_mag),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_comb begin
    if (CMP_W'(quotient) > CMP_W'(PMAX)) begin
      period_sat = PMAX;
    end else begin
      period_sat = PERIOD_WIDTH'(quotient);
    end
  end

  assign out_load = (state_r == S_FIN) & (!out_valid_r | out_tready);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    period_nxt = period_r;
    en_nxt     = en_r;
    dir_nxt    = dir_r;
    pulse_nxt  = pulse_r;
    stop_nxt   = stop_r;
    neg_nxt    = neg_r;
    zero_nxt   = zero_r;
    cnt_inc    = cnt_r + 1'b1;
    trk_ctl.pulse = 1'b0;
    trk_ctl.dir   = dir_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == REQ_COMMAND) begin
            neg_nxt   = vel_neg;
            zero_nxt  = (vel_mag == '0);
            stop_nxt  = (vel_mag == '0) || (vel_mag < MAG_W'(thr_r));
            pulse_nxt = 1'b0;
            state_nxt = S_DIV;
          end else begin
            pulse_nxt = 1'b0;
            if (en_r) begin
              if (cnt_inc >= period_r) begin
                cnt_nxt       = '0;
                pulse_nxt     = 1'b1;
                trk_ctl.pulse = 1'b1;
              end else begin
                cnt_nxt = cnt_inc;
              end
            end
            state_nxt = S_FIN;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          period_nxt = zero_r ? PMAX : period_sat;
          en_nxt     = !stop_r;
          if (!stop_r) begin
            dir_nxt = !neg_r;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  sspg_track #(
    .STEP_COUNT_WIDTH (STEP_COUNT_WIDTH)
  ) u_track (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (trk_ctl),
    .angle_per_pulse (app_r),
    .step_count      (step_count),
    .angle           (angle)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_DATA_W'({angle, STEP_OUT_W'(step_count),
                                   PER_OUT_W'(period_r), en_r, dir_r, pulse_r});
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      period_r    <= '0;
      en_r        <= 1'b0;
      dir_r       <= 1'b0;
      pulse_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      period_r    <= period_nxt;
      en_r        <= en_nxt;
      dir_r       <= dir_nxt;
      pulse_r     <= pulse_nxt;
      out_valid_r <= out_valid_nxt;
    end
    stop_r     <= stop_nxt;
    neg_r      <= neg_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("transaction accepted while another is in progress");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> state_r == S_DIV)
    else $error("divider active outside the divide state");

  a_pulse_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    trk_ctl.pulse |=> (cnt_r == '0) && en_r && pulse_r)
    else $error("step pulse without timer restart");

  a_pulse_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[0] |-> out_data_r[2])
    else $error("step pulse reported while stopped");

endmodule

`default_nettype wire

// File: hw/rtl/sspg_div.sv
// Bit-serial restoring divider for the step period.
// Produces one quotient bit per clock; uses sspg_pkg.
`default_nettype none

module sspg_div import sspg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [MAG_W-1:0] divisor,
  output div_stat_t             stat,
  output logic [NUM_W-1:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             active_r, active_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MAG_W-1:0] rem_r, rem_nxt;
  logic [MAG_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [MAG_W:0]   trial;
  logic [MAG_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, quo_r[NUM_W-1]};
    ge    = (trial >= {1'b0, den_r});
    diff  = trial - {1'b0, den_r};
  end

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    quo_nxt    = quo_r;
    if (start) begin
      active_nxt = 1'b1;
      cnt_nxt    = CNT_W'(NUM_W - 1);
      rem_nxt    = '0;
      den_nxt    = divisor;
      quo_nxt    = dividend;
    end else if (active_r) begin
      rem_nxt = ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = active_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !active_r)
    else $error("divider started while busy");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> active_r)
    else $error("divider did not start");

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(active_r) && !active_r)
    else $error("divider finished without running");

endmodule

`default_nettype wire

// File: hw/rtl/sspg_track.sv
// Position tracker: step count and shaft angle wrapped into (-pi, pi].
// Updated once per step pulse; uses sspg_pkg.
`default_nettype none

module sspg_track import sspg_pkg::*; #(
  parameter int unsigned STEP_COUNT_WIDTH = STEP_COUNT_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire trk_ctl_t                    ctl,
  input  wire logic [APP_W-1:0]            angle_per_pulse,
  output logic [STEP_COUNT_WIDTH-1:0]      step_count,
  output logic signed [ANG_W-1:0]          angle
);

  localparam logic signed [ANG_W:0] PI_EXT     = (ANG_W+1)'(PI_URAD);
  localparam logic signed [ANG_W:0] TWO_PI_EXT = (ANG_W+1)'(TWO_PI_URAD);

  logic [STEP_COUNT_WIDTH-1:0] step_r, step_nxt;
  logic signed [ANG_W-1:0]     ang_r, ang_nxt;
  logic signed [ANG_W:0]       ang_ext, app_ext, sum, wrapped;

  always_comb begin
    ang_ext = {ang_r[ANG_W-1], ang_r};
    app_ext = signed'({{(ANG_W + 1 - APP_W){1'b0}}, angle_per_pulse});
    sum     = ctl.dir ? (ang_ext + app_ext) : (ang_ext - app_ext);
    if (sum > PI_EXT) begin
      wrapped = sum - TWO_PI_EXT;
    end else if (sum <= -PI_EXT) begin
      wrapped = sum + TWO_PI_EXT;
    end else begin
      wrapped = sum;
    end
    step_nxt = step_r;
    ang_nxt  = ang_r;
    if (ctl.pulse) begin
      step_nxt = ctl.dir ? (step_r + 1'b1) : (step_r - 1'b1);
      ang_nxt  = wrapped[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      ang_r  <= '0;
    end else begin
      step_r <= step_nxt;
      ang_r  <= ang_nxt;
    end
  end

  assign step_count = step_r;
  assign angle      = ang_r;

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ang_r <= ANG_W'(PI_URAD)) && (ang_r > -ANG_W'(PI_URAD)))
    else $error("shaft angle outside (-pi, pi]");

  a_pulse_moves: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pulse |=> step_r != $past(step_r))
    else $error("step count unchanged after a pulse");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.pulse |=> $stable(step_r) && $stable(ang_r))
    else $error("position changed without a pulse");

endmodule

`default_nettype wire
